// File: rtl/resonant_lowpass_highpass_filter_defines.svh
// Assertion macros shared by the resonant low-pass / high-pass filter RTL.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef RESONANT_LOWPASS_HIGHPASS_FILTER_DEFINES_SVH
`define RESONANT_LOWPASS_HIGHPASS_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLHPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLHPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rlhpf_pkg.sv
// Shared widths, register codes, types and saturation helpers for the filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rlhpf_pkg;

  localparam int SW         = 16;
  localparam int STW        = 32;
  localparam int FRAC_SHIFT = (STW - 9) - (SW - 1);
  localparam int CW         = 16;
  localparam int GW         = 13;
  localparam int COEF_PAD   = CW - GW;
  localparam int CNT_W      = $clog2(CW + 1);
  localparam int IDX_W      = 3;
  localparam int CFG_DW     = 16;

  localparam logic [GW-1:0] GAIN_MAX     = GW'(6554);
  localparam logic [GW-1:0] HP_GAIN_MIN  = GW'(1);
  localparam logic [CW-1:0] DAMP_MIN     = CW'(3277);
  localparam logic [CW-1:0] DAMP_MAX     = CW'(52429);

  typedef enum logic [IDX_W-1:0] {
    CFG_LP_ENABLE  = 3'd0,
    CFG_LP_GAIN    = 3'd1,
    CFG_LP_DAMPING = 3'd2,
    CFG_HP_ENABLE  = 3'd3,
    CFG_HP_GAIN    = 3'd4
  } cfg_idx_t;

  typedef logic signed [SW-1:0]  sample_t;
  typedef logic signed [STW-1:0] state_t;
  typedef logic signed [STW:0]   op_t;
  typedef logic signed [STW+1:0] ext_t;

  typedef struct packed {
    logic          lp_en;
    logic [GW-1:0] lp_gain;
    logic [CW-1:0] lp_damp;
    logic          hp_en;
    logic [GW-1:0] hp_gain;
  } cfg_t;

  typedef struct packed {
    logic          start;
    logic          short_coef;
    op_t           a;
    logic [CW-1:0] coef;
  } mul_req_t;

  typedef struct packed {
    logic done;
    op_t  prod;
  } mul_rsp_t;

  function automatic state_t sat_state(input ext_t v);
    state_t r;
    if (v[STW+1:STW-1] == '0 || v[STW+1:STW-1] == '1) begin
      r = v[STW-1:0];
    end else if (v[STW+1]) begin
      r = {1'b1, {(STW-1){1'b0}}};
    end else begin
      r = {1'b0, {(STW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/resonant_lowpass_highpass_filter.sv
// Resonant low-pass followed by a one-pole high-pass on signed Q1.15 samples,
// one result word per input word. A word is taken only once the sequence for
// the previous word has ended; its length depends on which stages are enabled
// and is set by the single shared serial multiplier, which retires one
// coefficient bit per cycle (13, 16 and 13 bits for the three products) plus a
// rounding step and a handoff step each, and by the other steps of the sequence.
// A new word is taken while the previous result still waits on the output;
// the input stalls longer only while a finished result finds that output
// register still full. Configuration writes are never stalled.
`default_nettype none

module resonant_lowpass_highpass_filter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic signed [rlhpf_pkg::SW-1:0]    in_audio_in,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic signed [rlhpf_pkg::SW-1:0]    out_audio_out,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [rlhpf_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [rlhpf_pkg::CFG_DW-1:0]       cfg_data
);

  rlhpf_pkg::cfg_t cfg;

  rlhpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlhpf_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_audio_in   (in_audio_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_audio_out (out_audio_out)
  );

endmodule

`default_nettype wire

// File: rtl/rlhpf_cfg.sv
// Configuration register file with range clamping of the coefficients.
// Depends on rlhpf_pkg.
`default_nettype none

module rlhpf_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [rlhpf_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [rlhpf_pkg::CFG_DW-1:0]  cfg_data,
  output      rlhpf_pkg::cfg_t               cfg
);

  logic                        lp_en_r;
  logic [rlhpf_pkg::GW-1:0]    lp_gain_r;
  logic [rlhpf_pkg::CW-1:0]    lp_damp_r;
  logic                        hp_en_r;
  logic [rlhpf_pkg::GW-1:0]    hp_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_en_r   <= 1'b0;
      lp_gain_r <= '0;
      lp_damp_r <= rlhpf_pkg::DAMP_MIN;
      hp_en_r   <= 1'b0;
      hp_gain_r <= rlhpf_pkg::HP_GAIN_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rlhpf_pkg::cfg_idx_t'(cfg_index))
        rlhpf_pkg::CFG_LP_ENABLE:  lp_en_r   <= cfg_data[0];
        rlhpf_pkg::CFG_LP_GAIN:    lp_gain_r <= cfg_data[rlhpf_pkg::GW-1:0];
        rlhpf_pkg::CFG_LP_DAMPING: lp_damp_r <= cfg_data[rlhpf_pkg::CW-1:0];
        rlhpf_pkg::CFG_HP_ENABLE:  hp_en_r   <= cfg_data[0];
        rlhpf_pkg::CFG_HP_GAIN:    hp_gain_r <= cfg_data[rlhpf_pkg::GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.lp_en = lp_en_r;
    cfg.hp_en = hp_en_r;
    cfg.lp_gain = (lp_gain_r > rlhpf_pkg::GAIN_MAX) ? rlhpf_pkg::GAIN_MAX : lp_gain_r;
    if (lp_damp_r < rlhpf_pkg::DAMP_MIN) begin
      cfg.lp_damp = rlhpf_pkg::DAMP_MIN;
    end else if (lp_damp_r > rlhpf_pkg::DAMP_MAX) begin
      cfg.lp_damp = rlhpf_pkg::DAMP_MAX;
    end else begin
      cfg.lp_damp = lp_damp_r;
    end
    if (hp_gain_r < rlhpf_pkg::HP_GAIN_MIN) begin
      cfg.hp_gain = rlhpf_pkg::HP_GAIN_MIN;
    end else if (hp_gain_r > rlhpf_pkg::GAIN_MAX) begin
      cfg.hp_gain = rlhpf_pkg::GAIN_MAX;
    end else begin
      cfg.hp_gain = hp_gain_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rlhpf_mul.sv
// Serial-parallel multiplier: state operand times unsigned Q0.16 coefficient,
// one coefficient bit per cycle, result rounded to nearest. Depends on rlhpf_pkg.
`default_nettype none
`include "resonant_lowpass_highpass_filter_defines.svh"

module rlhpf_mul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rlhpf_pkg::mul_req_t req,
  output      rlhpf_pkg::mul_rsp_t rsp
);

  logic                            busy_r;
  logic                            fin_r;
  logic                            done_r;
  logic                            short_r;
  logic [rlhpf_pkg::CNT_W-1:0]     cnt_r;
  logic [rlhpf_pkg::CW-1:0]        coef_r;
  rlhpf_pkg::op_t                  a_r;
  rlhpf_pkg::op_t                  acc_r;
  logic                            rbit_r;
  rlhpf_pkg::ext_t                 step_sum;
  rlhpf_pkg::op_t                  rnd_bit;

  assign step_sum = rlhpf_pkg::ext_t'(acc_r)
                  + (coef_r[0] ? rlhpf_pkg::ext_t'(a_r) : rlhpf_pkg::ext_t'(0));
  assign rnd_bit  = short_r ? rlhpf_pkg::op_t'({{rlhpf_pkg::STW{1'b0}},
                                                acc_r[rlhpf_pkg::COEF_PAD-1]})
                            : rlhpf_pkg::op_t'({{rlhpf_pkg::STW{1'b0}}, rbit_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      if (req.start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
      end else if (busy_r && cnt_r == rlhpf_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end else begin
        fin_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r   <= '0;
      a_r     <= req.a;
      coef_r  <= req.coef;
      short_r <= req.short_coef;
      cnt_r   <= req.short_coef ? rlhpf_pkg::CNT_W'(rlhpf_pkg::GW)
                                : rlhpf_pkg::CNT_W'(rlhpf_pkg::CW);
    end else if (busy_r) begin
      acc_r  <= step_sum[rlhpf_pkg::STW+1:1];
      rbit_r <= step_sum[0];
      coef_r <= coef_r >> 1;
      cnt_r  <= cnt_r - rlhpf_pkg::CNT_W'(1);
    end else if (fin_r) begin
      if (short_r) begin
        acc_r <= (acc_r >>> rlhpf_pkg::COEF_PAD) + rnd_bit;
      end else begin
        acc_r <= acc_r + rnd_bit;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  `RLHPF_ASSERT_IMP(a_mul_start_idle, req.start, !(busy_r || fin_r || done_r), "multiplier restarted while busy")
  `RLHPF_ASSERT_IMP(a_mul_busy_from_start, $rose(busy_r), $past(req.start), "multiplier ran without a start")

endmodule

`default_nettype wire

// File: rtl/rlhpf_core.sv
// Filter sequencer: low-pass and high-pass state, the update sequence built
// around one shared serial multiplier, and the output register. Depends on
// rlhpf_pkg and rlhpf_mul.
`default_nettype none
`include "resonant_lowpass_highpass_filter_defines.svh"

module rlhpf_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rlhpf_pkg::cfg_t         cfg,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire rlhpf_pkg::sample_t      in_audio_in,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      rlhpf_pkg::sample_t      out_audio_out
);

  localparam int RQ_W = rlhpf_pkg::STW - rlhpf_pkg::FRAC_SHIFT + 1;
  localparam int EXT_W = rlhpf_pkg::STW - rlhpf_pkg::SW - rlhpf_pkg::FRAC_SHIFT;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_LP_M1  = 10'b0000000010,
    ST_LP_S2  = 10'b0000000100,
    ST_LP_M2  = 10'b0000001000,
    ST_LP_POS = 10'b0000010000,
    ST_HP_D   = 10'b0000100000,
    ST_HP_A1  = 10'b0001000000,
    ST_HP_S   = 10'b0010000000,
    ST_HP_M   = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  rlhpf_pkg::state_t         pos_r;
  rlhpf_pkg::state_t         vel_r;
  rlhpf_pkg::state_t         acc_r;
  rlhpf_pkg::state_t         prev_r;
  rlhpf_pkg::op_t            t_r;
  logic                      out_valid_r;
  rlhpf_pkg::sample_t        out_data_r;
  logic                      accept;
  logic                      out_load;
  rlhpf_pkg::state_t         x_in;
  rlhpf_pkg::state_t         res;
  rlhpf_pkg::op_t            res_sum;
  logic signed [RQ_W-1:0]    res_q;
  rlhpf_pkg::sample_t        res_sat;
  rlhpf_pkg::mul_req_t       mreq;
  rlhpf_pkg::mul_rsp_t       mrsp;

  rlhpf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_audio_out = out_data_r;

  assign x_in = {{EXT_W{in_audio_in[rlhpf_pkg::SW-1]}}, in_audio_in,
                 {rlhpf_pkg::FRAC_SHIFT{1'b0}}};

  assign res     = cfg.hp_en ? acc_r : pos_r;
  assign res_sum = rlhpf_pkg::op_t'(res)
                 + rlhpf_pkg::op_t'(1 << (rlhpf_pkg::FRAC_SHIFT - 1));
  assign res_q   = res_sum[rlhpf_pkg::STW:rlhpf_pkg::FRAC_SHIFT];

  always_comb begin
    if (res_q[RQ_W-1:rlhpf_pkg::SW-1] == '0 || res_q[RQ_W-1:rlhpf_pkg::SW-1] == '1) begin
      res_sat = res_q[rlhpf_pkg::SW-1:0];
    end else if (res_q[RQ_W-1]) begin
      res_sat = {1'b1, {(rlhpf_pkg::SW-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(rlhpf_pkg::SW-1){1'b1}}};
    end
  end

  always_comb begin
    mreq.start      = 1'b0;
    mreq.short_coef = 1'b1;
    mreq.a          = rlhpf_pkg::op_t'(rlhpf_pkg::op_t'(x_in) - rlhpf_pkg::op_t'(pos_r));
    mreq.coef       = {{rlhpf_pkg::COEF_PAD{1'b0}}, cfg.lp_gain};
    unique case (state_r)
      ST_IDLE: begin
        mreq.start = accept && cfg.lp_en;
      end
      ST_LP_S2: begin
        mreq.start      = 1'b1;
        mreq.short_coef = 1'b0;
        mreq.a          = rlhpf_pkg::op_t'(vel_r);
        mreq.coef       = cfg.lp_damp;
      end
      ST_HP_S: begin
        mreq.start = 1'b1;
        mreq.a     = rlhpf_pkg::op_t'(acc_r);
        mreq.coef  = {{rlhpf_pkg::COEF_PAD{1'b0}}, cfg.hp_gain};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = cfg.lp_en ? ST_LP_M1 : ST_HP_D;
        end
      end
      ST_LP_M1: begin
        if (mrsp.done) begin
          state_nxt = ST_LP_S2;
        end
      end
      ST_LP_S2:  state_nxt = ST_LP_M2;
      ST_LP_M2: begin
        if (mrsp.done) begin
          state_nxt = ST_LP_POS;
        end
      end
      ST_LP_POS: state_nxt = ST_HP_D;
      ST_HP_D:   state_nxt = cfg.hp_en ? ST_HP_A1 : ST_OUT;
      ST_HP_A1:  state_nxt = ST_HP_S;
      ST_HP_S:   state_nxt = ST_HP_M;
      ST_HP_M: begin
        if (mrsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            prev_r <= pos_r;
            if (!cfg.lp_en) begin
              pos_r <= x_in;
              vel_r <= '0;
            end
          end
        end
        ST_LP_M1: begin
          if (mrsp.done) begin
            vel_r <= rlhpf_pkg::sat_state(rlhpf_pkg::ext_t'(vel_r)
                                          + rlhpf_pkg::ext_t'(mrsp.prod));
          end
        end
        ST_LP_M2: begin
          if (mrsp.done) begin
            vel_r <= rlhpf_pkg::sat_state(rlhpf_pkg::ext_t'(vel_r)
                                          - rlhpf_pkg::ext_t'(mrsp.prod));
          end
        end
        ST_LP_POS: begin
          pos_r <= rlhpf_pkg::sat_state(rlhpf_pkg::ext_t'(pos_r)
                                        + rlhpf_pkg::ext_t'(vel_r));
        end
        ST_HP_D: begin
          if (cfg.hp_en) begin
            t_r <= rlhpf_pkg::op_t'(rlhpf_pkg::op_t'(pos_r) - rlhpf_pkg::op_t'(prev_r));
          end else begin
            acc_r <= '0;
          end
        end
        ST_HP_A1: begin
          acc_r <= rlhpf_pkg::sat_state(rlhpf_pkg::ext_t'(acc_r)
                                        + rlhpf_pkg::ext_t'(t_r));
        end
        ST_HP_M: begin
          if (mrsp.done) begin
            acc_r <= rlhpf_pkg::sat_state(rlhpf_pkg::ext_t'(acc_r)
                                          - rlhpf_pkg::ext_t'(mrsp.prod));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_sat;
    end
  end

  `RLHPF_ASSERT_IMP(a_core_done_waited, mrsp.done, state_r == ST_LP_M1 || state_r == ST_LP_M2 || state_r == ST_HP_M, "product arrived in a state that does not wait for it")
  `RLHPF_ASSERT_IMP(a_core_out_from_out, $rose(out_valid_r), $past(state_r == ST_OUT), "output word loaded outside the output state")

endmodule

`default_nettype wire

// File: sim/resonant_lowpass_highpass_filter_test.sv
// Self-checking testbench for the resonant low-pass / one-pole high-pass filter.
// Drives sample words and register writes, predicts every output word in fixed point,
// and compares. Depends on rlhpf_pkg and the resonant_lowpass_highpass_filter RTL.
`default_nettype none

module resonant_lowpass_highpass_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlhpf_pkg::*;

  localparam int GAP_MAX      = 19;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_WORDS = 470;

  typedef enum int {SIG_NOISE, SIG_EXTREME, SIG_QUIET, SIG_STEPS} signal_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              in_audio_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              out_audio_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;

  sample_t queued_samples[$];
  sample_t expected_audio[$];

  cfg_t   filt_cfg;
  longint lp_pos;
  longint lp_vel;
  longint hp_acc;

  int tx_gap_max = GAP_MAX;
  int rx_gap_max = GAP_MAX;
  int tx_wait = 0;
  int rx_wait = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  sample_t step_value = '0;
  int step_left = 0;

  resonant_lowpass_highpass_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_audio_in  (in_audio_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_audio_out(out_audio_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint saturate(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic longint scale_q16(longint a, longint c);
    return (a * c + 32768) >>> 16;
  endfunction

  function automatic sample_t filter_sample(sample_t s);
    longint x;
    longint prev;
    longint lp_out;
    longint res;
    longint g;
    longint dm;
    x = longint'(s) <<< FRAC_SHIFT;
    prev = lp_pos;
    if (filt_cfg.lp_en) begin
      g = (filt_cfg.lp_gain > GAIN_MAX) ? GAIN_MAX : filt_cfg.lp_gain;
      dm = filt_cfg.lp_damp;
      if (filt_cfg.lp_damp < DAMP_MIN) begin
        dm = DAMP_MIN;
      end else if (filt_cfg.lp_damp > DAMP_MAX) begin
        dm = DAMP_MAX;
      end
      lp_vel = saturate(lp_vel + scale_q16(x - lp_pos, g), STW);
      lp_vel = saturate(lp_vel - scale_q16(lp_vel, dm), STW);
      lp_pos = saturate(lp_pos + lp_vel, STW);
      lp_out = lp_pos;
    end else begin
      lp_pos = x;
      lp_vel = 0;
      lp_out = x;
    end
    if (filt_cfg.hp_en) begin
      g = filt_cfg.hp_gain;
      if (filt_cfg.hp_gain < HP_GAIN_MIN) begin
        g = HP_GAIN_MIN;
      end else if (filt_cfg.hp_gain > GAIN_MAX) begin
        g = GAIN_MAX;
      end
      hp_acc = saturate(hp_acc + (lp_out - prev), STW);
      hp_acc = saturate(hp_acc - scale_q16(hp_acc, g), STW);
      res = hp_acc;
    end else begin
      hp_acc = 0;
      res = lp_out;
    end
    res = saturate((res + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT, SW);
    return res[SW-1:0];
  endfunction

  function automatic sample_t draw_level();
    case ($urandom_range(0, 2))
      0: return sample_t'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? sample_t'(32767) : sample_t'(-32768);
      default: return sample_t'($urandom_range(0, 1023)) - sample_t'(512);
    endcase
  endfunction

  function automatic sample_t next_sample(signal_kind_t kind);
    case (kind)
      SIG_NOISE: return sample_t'($urandom);
      SIG_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(32767);
          1: return sample_t'(-32768);
          2: return sample_t'(0);
          default: return sample_t'(-1);
        endcase
      end
      SIG_QUIET: return sample_t'($urandom_range(0, 511)) - sample_t'(256);
      default: begin
        if (step_left == 0) begin
          step_value = draw_level();
          step_left = $urandom_range(5, 40);
        end
        step_left--;
        return step_value;
      end
    endcase
  endfunction

  function automatic signal_kind_t pick_kind();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return SIG_NOISE;
      4, 5, 6: return SIG_EXTREME;
      7, 8, 9: return SIG_QUIET;
      default: return SIG_STEPS;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_reg_value(logic [IDX_W-1:0] idx);
    logic [CFG_DW-1:0] v;
    int lo;
    int hi;
    v = CFG_DW'($urandom);
    lo = 0;
    hi = int'(GAIN_MAX);
    case (idx)
      CFG_LP_ENABLE, CFG_HP_ENABLE: begin
        v[0] = ($urandom_range(0, 3) != 0);
        return v;
      end
      CFG_LP_GAIN: begin
        lo = 0;
        hi = int'(GAIN_MAX);
      end
      CFG_LP_DAMPING: begin
        lo = int'(DAMP_MIN);
        hi = int'(DAMP_MAX);
      end
      CFG_HP_GAIN: begin
        lo = int'(HP_GAIN_MIN);
        hi = int'(GAIN_MAX);
      end
      default: return v;
    endcase
    case ($urandom_range(0, 7))
      0: v = CFG_DW'(lo);
      1: v = CFG_DW'(hi);
      2: v = '0;
      3: v = '1;
      4: ;
      default: v = CFG_DW'($urandom_range(lo, hi));
    endcase
    return v;
  endfunction

  task automatic note_mismatch(string what, sample_t want, sample_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Must be called at a rising edge; leaves cfg_valid high for a following write.
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LP_ENABLE: filt_cfg.lp_en = data[0];
      CFG_LP_GAIN: filt_cfg.lp_gain = data[GW-1:0];
      CFG_LP_DAMPING: filt_cfg.lp_damp = data[CW-1:0];
      CFG_HP_ENABLE: filt_cfg.hp_en = data[0];
      CFG_HP_GAIN: filt_cfg.hp_gain = data[GW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(logic [CFG_DW-1:0] lp_en, logic [CFG_DW-1:0] lp_gain,
                                logic [CFG_DW-1:0] lp_damp, logic [CFG_DW-1:0] hp_en,
                                logic [CFG_DW-1:0] hp_gain);
    cfg_write(CFG_LP_ENABLE, lp_en);
    cfg_write(CFG_LP_GAIN, lp_gain);
    cfg_write(CFG_LP_DAMPING, lp_damp);
    cfg_write(CFG_HP_ENABLE, hp_en);
    cfg_write(CFG_HP_GAIN, hp_gain);
    cfg_valid <= 1'b0;
  endtask

  task automatic randomize_settings();
    int n;
    logic [IDX_W-1:0] idx;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        idx = IDX_W'($urandom_range(CFG_HP_GAIN + 1, (1 << IDX_W) - 1));
      end else begin
        idx = IDX_W'($urandom_range(CFG_LP_ENABLE, CFG_HP_GAIN));
      end
      cfg_write(idx, pick_reg_value(idx));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic push_words(sample_t vals[$]);
    @(negedge clk);
    foreach (vals[i]) queued_samples.push_back(vals[i]);
  endtask

  task automatic push_random(int n, signal_kind_t kind);
    @(negedge clk);
    step_left = 0;
    for (int i = 0; i < n; i++) begin
      queued_samples.push_back(next_sample(kind));
    end
  endtask

  // Returns at a rising edge once every sample is sent and every result is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_samples.size() != 0 || in_valid || expected_audio.size() != 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_audio_in <= '0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_audio.push_back(filter_sample(in_audio_in));
        tx_wait = $urandom_range(0, tx_gap_max);
      end
      if (in_valid && !in_ready) begin
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (queued_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_audio_in <= queued_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_audio.size() == 0) begin
          note_mismatch("output word with nothing expected", '0, out_audio_out);
        end else if (out_audio_out !== expected_audio[0]) begin
          note_mismatch("audio_out mismatch", expected_audio.pop_front(), out_audio_out);
        end else begin
          void'(expected_audio.pop_front());
        end
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int n;
    filt_cfg = '{lp_en: 1'b0, lp_gain: '0, lp_damp: DAMP_MIN, hp_en: 1'b0,
                 hp_gain: HP_GAIN_MIN};
    lp_pos = 0;
    lp_vel = 0;
    hp_acc = 0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both stages bypassed after reset.
    push_words('{-32768, 32767, 0, -1, 1});
    wait_drained();

    // Out-of-range gains and damping, plus a write to an unused index.
    cfg_write(IDX_W'(CFG_HP_GAIN + 1), '1);
    write_settings(1, 16'hFFFF, 16'h0000, 1, 16'h0000);
    push_words('{32767, 32767, 32767, -32768, -32768, -32768});
    wait_drained();

    write_settings(1, GAIN_MAX, 16'hFFFF, 1, GAIN_MAX);
    push_words('{-32768, 32767, -32768, 32767, 0});
    wait_drained();

    write_settings(0, 0, DAMP_MIN, 1, 16'h1FFF);
    push_words('{32767, -32768, 32767, -32768, -1});
    wait_drained();

    write_settings(1, 1, DAMP_MAX, 0, HP_GAIN_MIN);
    push_words('{32767, 32767, -32768, 1});
    wait_drained();

    // Output side stalls for a long stretch while the input is offered back to back.
    write_settings(1, GAIN_MAX, DAMP_MIN, 1, 100);
    @(negedge clk);
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_reqs++;
    push_random(40, SIG_STEPS);
    wait_drained();

    while (sent < RANDOM_WORDS) begin
      randomize_settings();
      @(negedge clk);
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      n = $urandom_range(10, 50);
      push_random(n, pick_kind());
      sent += n;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_audio.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
